@@ rtl/tcon_pkg.sv @@
// package for the text console: payload structs, codes, scancode map
// no dependencies
package tcon_pkg;

  localparam int unsigned COLUMNS_DEF    = 80;
  localparam int unsigned ROWS_DEF       = 25;
  localparam int unsigned LINE_DEPTH_DEF = 64;
  localparam int unsigned POS_W          = 11;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_KEY   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic       CFG_ATTR   = 1'b0;
  localparam logic       CFG_MAXLEN = 1'b1;

  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_UP = 8'hB6;
  localparam logic [7:0] SC_BREAK     = 8'h80;
  localparam logic [7:0] SC_BKSP      = 8'h0E;
  localparam logic [7:0] SC_ENTER     = 8'h1C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h07;
  localparam logic [6:0] MAXLEN_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [7:0]  scancode;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
    logic        line_char_valid;
    logic [7:0]  line_char;
    logic        line_done;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_RD_WAIT, ST_SCROLL_RD, ST_SCROLL_WR, ST_BLANK,
    ST_LINE_RD, ST_LINE_OUT, ST_DONE_OUT, ST_OUT
  } state_e;

  // set-1 make code to ascii; bit 8 marks a mapped code
  function automatic logic [8:0] key_map(input logic [7:0] sc, input logic sh);
    logic [7:0] c;
    logic       ok;
    c  = 8'h00;
    ok = 1'b1;
    unique case (sc)
      8'h02: c = sh ? "!" : "1";
      8'h03: c = sh ? "@" : "2";
      8'h04: c = sh ? "#" : "3";
      8'h05: c = sh ? "$" : "4";
      8'h06: c = sh ? "%" : "5";
      8'h07: c = sh ? "^" : "6";
      8'h08: c = sh ? "&" : "7";
      8'h09: c = sh ? "*" : "8";
      8'h0A: c = sh ? "(" : "9";
      8'h0B: c = sh ? ")" : "0";
      8'h0C: c = sh ? "_" : "-";
      8'h0D: c = sh ? "+" : "=";
      8'h10: c = sh ? "Q" : "q";
      8'h11: c = sh ? "W" : "w";
      8'h12: c = sh ? "E" : "e";
      8'h13: c = sh ? "R" : "r";
      8'h14: c = sh ? "T" : "t";
      8'h15: c = sh ? "Y" : "y";
      8'h16: c = sh ? "U" : "u";
      8'h17: c = sh ? "I" : "i";
      8'h18: c = sh ? "O" : "o";
      8'h19: c = sh ? "P" : "p";
      8'h1E: c = sh ? "A" : "a";
      8'h1F: c = sh ? "S" : "s";
      8'h20: c = sh ? "D" : "d";
      8'h21: c = sh ? "F" : "f";
      8'h22: c = sh ? "G" : "g";
      8'h23: c = sh ? "H" : "h";
      8'h24: c = sh ? "J" : "j";
      8'h25: c = sh ? "K" : "k";
      8'h26: c = sh ? "L" : "l";
      8'h27: c = sh ? ":" : ";";
      8'h2C: c = sh ? "Z" : "z";
      8'h2D: c = sh ? "X" : "x";
      8'h2E: c = sh ? "C" : "c";
      8'h2F: c = sh ? "V" : "v";
      8'h30: c = sh ? "B" : "b";
      8'h31: c = sh ? "N" : "n";
      8'h32: c = sh ? "M" : "m";
      8'h33: c = sh ? "<" : ",";
      8'h34: c = sh ? ">" : ".";
      8'h35: c = sh ? "?" : "/";
      8'h39: c = " ";
      default: ok = 1'b0;
    endcase
    return {ok, c};
  endfunction

endpackage

@@ rtl/tcon_ram.sv @@
// generic single-port-write ram with registered read
// no dependencies
module tcon_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/text_console_with_line_input.sv @@
// text console top: sequencer over a shared cell-store port and line buffer ram
// uses tcon_pkg, tcon_ram
// a write or key word with no scroll or line output shows its result the cycle after accept;
//   a read first goes through the registered store read
// a scroll alternates store read and write states over the store, then blanks the last row; clear blanks every cell
// enter gives line_count+1 results: one per character, then the closing result
// throughput: one word at a time; in_stall is high until the last result is taken
// reset: a clearing pass blanks every cell of the store before the first word
module text_console_with_line_input
  import tcon_pkg::*;
#(
  parameter int unsigned COLUMNS    = COLUMNS_DEF,
  parameter int unsigned ROWS       = ROWS_DEF,
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data_i,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data_o,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned LW    = $clog2(LINE_DEPTH);
  localparam int unsigned NW    = LW + 1;

  state_e st_q, st_d;
  logic [7:0]  attr_q;
  logic [6:0]  maxlen_q;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic shift_q, shift_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [AW:0]   ptr_q, ptr_d;
  logic [NW-1:0] li_q, li_d;
  out_word_t res_q, res_d;
  logic [10:0] rd_idx_q, rd_idx_d;

  // shared cell store port
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [15:0]   s_wd, s_rd;
  logic          l_we;
  logic [LW-1:0] l_wa, l_ra;
  logic [7:0]    l_wd, l_rd;

  tcon_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );
  tcon_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd)
  );

  logic [15:0] blank;
  logic [AW-1:0] cur_addr;
  logic [11+AW:0] cur_pos_w;
  logic [8:0] km;
  logic [NW-1:0] lim;
  logic accept;

  assign blank     = {attr_q, CH_SPACE};
  assign cur_pos_w = (12+AW)'(row_q) * (12+AW)'(COLUMNS) + (12+AW)'(col_q);
  assign cur_addr  = cur_pos_w[AW-1:0];
  assign km        = key_map(in_data_i.scancode, shift_q);
  assign lim       = (maxlen_q > 7'(LINE_DEPTH)) ? NW'(LINE_DEPTH) : NW'(maxlen_q);
  assign accept    = in_valid && !in_stall;

  assign in_stall  = (st_q != ST_IDLE);
  // register writes only land while idle with no word offered
  assign cfg_ready = (st_q == ST_IDLE) && !in_valid;
  assign out_valid = (st_q == ST_OUT) || (st_q == ST_LINE_OUT) || (st_q == ST_DONE_OUT);
  assign out_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_INIT;
      attr_q   <= ATTR_RESET;
      maxlen_q <= MAXLEN_RESET;
      row_q    <= '0;
      col_q    <= '0;
      shift_q  <= 1'b0;
      cnt_q    <= '0;
      ptr_q    <= '0;
      li_q     <= '0;
    end else begin
      st_q    <= st_d;
      row_q   <= row_d;
      col_q   <= col_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      li_q    <= li_d;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_i)
          CFG_ATTR:   attr_q   <= cfg_data_i;
          CFG_MAXLEN: maxlen_q <= cfg_data_i[6:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    rd_idx_q <= rd_idx_d;
  end

  // sequencer next-state logic: sets row/col, picks scroll path, drives both rams and the result
  always_comb begin
    st_d = st_q; row_d = row_q; col_d = col_q; shift_d = shift_q; cnt_d = cnt_q;
    ptr_d = ptr_q; li_d = li_q; res_d = res_q; rd_idx_d = rd_idx_q;
    s_we = 1'b0; s_wa = cur_addr; s_wd = blank; s_ra = ptr_q[AW-1:0];
    l_we = 1'b0; l_wa = cnt_q[LW-1:0]; l_wd = km[7:0]; l_ra = '0;
    unique case (st_q)
      ST_INIT, ST_BLANK: begin
        // blank sweep from ptr to end of store
        s_we = 1'b1; s_wa = ptr_q[AW-1:0];
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == (AW+1)'(CELLS-1)) begin
          st_d = (st_q == ST_INIT) ? ST_IDLE : ST_OUT;
        end
      end
      ST_IDLE: begin
        res_d = '0; res_d.last = 1'b1;
        if (accept) begin
          st_d = ST_OUT;
          unique case (in_data_i.func)
            FUNC_WRITE: begin
              if (in_data_i.char_code == CH_NEWLINE) begin
                col_d = '0;
                if (row_q == RW'(ROWS-1)) begin st_d = ST_SCROLL_RD; ptr_d = (AW+1)'(COLUMNS); end
                else row_d = row_q + 1'b1;
              end else begin
                s_we = 1'b1; s_wd = {attr_q, in_data_i.char_code};
                if (col_q == CW'(COLUMNS-1)) begin
                  col_d = '0;
                  if (row_q == RW'(ROWS-1)) begin st_d = ST_SCROLL_RD; ptr_d = (AW+1)'(COLUMNS); end
                  else row_d = row_q + 1'b1;
                end else col_d = col_q + 1'b1;
              end
            end
            FUNC_CLEAR: begin
              row_d = '0; col_d = '0; ptr_d = '0; st_d = ST_BLANK;
            end
            FUNC_KEY: begin
              priority if (in_data_i.scancode == SC_LSHIFT || in_data_i.scancode == SC_RSHIFT)
                shift_d = 1'b1;
              else if (in_data_i.scancode == SC_LSHIFT_UP ||
                       in_data_i.scancode == SC_RSHIFT_UP)
                shift_d = 1'b0;
              else if ((in_data_i.scancode & SC_BREAK) != 8'h00) ;
              else if (in_data_i.scancode == SC_BKSP) begin
                if (cnt_q != '0) begin
                  cnt_d = cnt_q - 1'b1;
                  s_we = 1'b1;
                  if (col_q != '0) begin
                    col_d = col_q - 1'b1; s_wa = cur_addr - 1'b1;
                  end
                end
              end else if (in_data_i.scancode == SC_ENTER) begin
                shift_d = 1'b0; col_d = '0; li_d = '0;
                st_d = (cnt_q != '0) ? ST_LINE_RD : ST_DONE_OUT;
                if (row_q == RW'(ROWS-1)) begin st_d = ST_SCROLL_RD; ptr_d = (AW+1)'(COLUMNS); end
                else row_d = row_q + 1'b1;
              end else if (km[8] && (cnt_q + 1'b1 < lim)) begin
                l_we = 1'b1; cnt_d = cnt_q + 1'b1;
                s_we = 1'b1; s_wd = {attr_q, km[7:0]};
                if (col_q == CW'(COLUMNS-1)) begin
                  col_d = '0;
                  if (row_q == RW'(ROWS-1)) begin st_d = ST_SCROLL_RD; ptr_d = (AW+1)'(COLUMNS); end
                  else row_d = row_q + 1'b1;
                end else col_d = col_q + 1'b1;
              end
            end
            FUNC_READ: begin
              rd_idx_d = in_data_i.cell_index;
              s_ra = AW'(in_data_i.cell_index);
              st_d = ST_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: begin
        res_d.cell_data = (32'(rd_idx_q) < CELLS) ? s_rd : 16'h0000;
        st_d = ST_OUT;
      end
      ST_SCROLL_RD: begin
        // read cell ptr, next cycle write it at ptr-COLUMNS
        st_d = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        s_we = 1'b1; s_wa = AW'(ptr_q - (AW+1)'(COLUMNS)); s_wd = s_rd;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == (AW+1)'(CELLS-1)) begin
          ptr_d = (AW+1)'(CELLS - COLUMNS);
          st_d = ST_BLANK;
        end else st_d = ST_SCROLL_RD;
      end
      ST_LINE_RD: begin
        // line buffer output already holds entry li_q; load it as a character word
        res_d = '0; res_d.line_char_valid = 1'b1; res_d.line_char = l_rd;
        st_d = ST_LINE_OUT;
      end
      ST_LINE_OUT: begin
        if (!out_stall) begin
          li_d = li_q + 1'b1;
          res_d = '0; res_d.last = 1'b1; res_d.line_done = 1'b1;
          st_d = (li_d == cnt_q) ? ST_DONE_OUT : ST_LINE_RD;
        end
      end
      ST_DONE_OUT, ST_OUT: begin
        if (st_q == ST_DONE_OUT) begin res_d.line_done = 1'b1; cnt_d = '0; end
        if (!out_stall) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    // scroll finishing into line output after enter
    if (st_q == ST_BLANK && st_d == ST_OUT && ptr_q == (AW+1)'(CELLS-1) && res_q.line_done)
      st_d = (cnt_q != '0) ? ST_LINE_RD : ST_DONE_OUT;
    // flag enter through scroll/blank by marking the held result
    if (st_q == ST_IDLE && accept && in_data_i.func == FUNC_KEY &&
        in_data_i.scancode == SC_ENTER) res_d.line_done = 1'b1;
    res_d.cursor_pos = 11'(32'(row_d) * COLUMNS + 32'(col_d));
    // read address follows the next line index so the data is ready once that index is registered
    l_ra = li_d[LW-1:0];
  end

  // results only leave while the sequencer holds an output state
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !cfg_ready) else $error("result shown while idle");
  a_line_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LINE_OUT) |-> (li_q < cnt_q)) else $error("line index past count");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < NW'(LINE_DEPTH)) else $error("line count overflow");
endmodule
